>>> rtl/lir_pkg.sv
// Shared constants, control types and the microcode table of the increasing-run engine.
package lir_pkg;

	localparam int MAX_ITEMS  = 1024;
	localparam int VALUE_BITS = 32;

	// Index and count widths that follow from the table depth
	localparam int ADDR_W = $clog2(MAX_ITEMS);
	localparam int LEN_W  = $clog2(MAX_ITEMS + 1);

	// Port field widths
	localparam int IN_VALUE_W  = 32;
	localparam int OUT_LEN_W   = 11;
	localparam int OUT_REM_W   = 10;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_LEN_W - OUT_REM_W;

	// Microprogram addresses
	localparam int STEP_W = 2;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_IDLE  = 2'd0;
	localparam step_t STEP_PROBE = 2'd1;
	localparam step_t STEP_CMP   = 2'd2;
	localparam step_t STEP_PLACE = 2'd3;

	// Branch conditions
	typedef enum logic [1:0] {
		COND_ALWAYS   = 2'd0,
		COND_IN_FIRE  = 2'd1,
		COND_LO_LT_HI = 2'd2,
		COND_PLACE_OK = 2'd3
	} cond_t;

	typedef struct packed {
		logic  take_in;
		logic  probe;
		logic  cmp;
		logic  place;
		cond_t cond;
		step_t jmp_t;
		step_t jmp_f;
	} ucode_t;

	// Datapath strobes from the sequencer
	typedef struct packed {
		logic load;
		logic probe;
		logic cmp;
		logic place;
	} lir_ctl_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic lo_lt_hi;
		logic place_ok;
	} lir_sts_t;

	function automatic ucode_t ucode_rom(input step_t addr);
		ucode_t w;
		w = '0;
		case (addr)
			STEP_IDLE: begin
				w.take_in = 1'b1;
				w.cond    = COND_IN_FIRE;
				w.jmp_t   = STEP_PROBE;
				w.jmp_f   = STEP_IDLE;
			end
			STEP_PROBE: begin
				w.probe = 1'b1;
				w.cond  = COND_LO_LT_HI;
				w.jmp_t = STEP_CMP;
				w.jmp_f = STEP_PLACE;
			end
			STEP_CMP: begin
				w.cmp   = 1'b1;
				w.cond  = COND_ALWAYS;
				w.jmp_t = STEP_PROBE;
				w.jmp_f = STEP_PROBE;
			end
			STEP_PLACE: begin
				w.place = 1'b1;
				w.cond  = COND_PLACE_OK;
				w.jmp_t = STEP_IDLE;
				w.jmp_f = STEP_PLACE;
			end
			default: begin
				w.cond  = COND_ALWAYS;
				w.jmp_t = STEP_IDLE;
				w.jmp_f = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> rtl/lir_seq.sv
// Microprogram sequencer: step counter, control store and branch logic.
module lir_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  lir_pkg::lir_sts_t sts,
	output lir_pkg::lir_ctl_t ctl
);
	import lir_pkg::*;

	step_t  pc_q;
	ucode_t word;
	logic   cond_ok;

	always_comb begin
		word = ucode_rom(pc_q);
		case (word.cond)
			COND_ALWAYS:   cond_ok = 1'b1;
			COND_IN_FIRE:  cond_ok = s_tvalid;
			COND_LO_LT_HI: cond_ok = sts.lo_lt_hi;
			COND_PLACE_OK: cond_ok = sts.place_ok;
			default:       cond_ok = 1'b1;
		endcase
		s_tready  = word.take_in;
		ctl.load  = word.take_in & s_tvalid;
		ctl.probe = word.probe;
		ctl.cmp   = word.cmp;
		// hold the place step of a last item until the result register is free
		ctl.place = word.place & cond_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= cond_ok ? word.jmp_t : word.jmp_f;
		end
	end

endmodule

>>> rtl/lir_dpath.sv
// Datapath: tail memory, search bounds, counters and result register.
module lir_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lir_pkg::lir_ctl_t                  ctl,
	output lir_pkg::lir_sts_t                  sts,
	input  logic [lir_pkg::IN_VALUE_W-1:0]     in_value,
	input  logic                               in_last,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic [lir_pkg::OUT_LEN_W-1:0]      res_len,
	output logic [lir_pkg::OUT_REM_W-1:0]      res_rem
);
	import lir_pkg::*;

	logic [VALUE_BITS-1:0] tail_mem [MAX_ITEMS];

	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] rd_q;
	logic                  last_q;
	logic [LEN_W-1:0]      lo_q;
	logic [LEN_W-1:0]      hi_q;
	logic [LEN_W-1:0]      mid_q;
	logic [LEN_W-1:0]      used_q;
	logic [LEN_W-1:0]      count_q;
	logic                  out_valid_q;
	logic [OUT_LEN_W-1:0]  out_len_q;
	logic [OUT_REM_W-1:0]  out_rem_q;

	logic [LEN_W-1:0] mid;
	logic [LEN_W-1:0] diff;
	logic             grow;
	logic             do_write;
	logic [LEN_W-1:0] new_used;
	logic [LEN_W-1:0] rem_full;

	always_comb begin
		diff     = hi_q - lo_q;
		mid      = lo_q + (diff >> 1);
		grow     = (lo_q == used_q) && (used_q != LEN_W'(MAX_ITEMS));
		do_write = ctl.place && ((lo_q != used_q) || grow);
		new_used = grow ? used_q + LEN_W'(1) : used_q;
		rem_full = count_q - new_used;
		sts.lo_lt_hi = lo_q < hi_q;
		sts.place_ok = !last_q || !out_valid_q || res_ready;
	end

	// tail store: one read port for the search, one write port for placement
	always_ff @(posedge clk) begin
		if (ctl.probe) begin
			rd_q <= tail_mem[mid[ADDR_W-1:0]];
		end
		if (do_write) begin
			tail_mem[lo_q[ADDR_W-1:0]] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q  <= in_value[VALUE_BITS-1:0];
			last_q <= in_last;
		end
		if (ctl.probe) begin
			mid_q <= mid;
		end
		if (ctl.place && last_q) begin
			out_len_q <= OUT_LEN_W'(new_used);
			out_rem_q <= rem_full[OUT_REM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q        <= '0;
			hi_q        <= '0;
			used_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				lo_q <= '0;
				hi_q <= used_q;
				if (count_q != LEN_W'(MAX_ITEMS)) begin
					count_q <= count_q + LEN_W'(1);
				end
			end
			if (ctl.cmp) begin
				if (rd_q < val_q) begin
					lo_q <= mid_q + LEN_W'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.place) begin
				if (last_q) begin
					used_q      <= '0;
					count_q     <= '0;
					out_valid_q <= 1'b1;
				end else begin
					used_q <= new_used;
				end
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_len   = out_len_q;
	assign res_rem   = out_rem_q;

endmodule

>>> rtl/longest_increasing_run_engine_top.sv
// Top level of the longest strictly increasing run engine.
//
//  channel | direction | tdata (low bit first)                  | tlast
//  s_*     | in        | value[31:0]                            | last_item
//  m_*     | out       | longest_length[10:0], removals_needed  | -
//          |           | [20:11], zero [23:21]                  |
//
// An item takes the idle step, k lower-bound search halvings over the used part of
// the tail table (0..11 for 1024 entries), a final probe and the place step; each
// halving is a tail memory read and a compare. The result register lets the next
// transaction enter while a result waits; only a last item stalls until it is free.
// Reset clears the counters and sequencer; the tail memory needs no clearing.
module longest_increasing_run_engine_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lir_pkg::IN_VALUE_W-1:0]    s_tdata,  // value
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lir_pkg::OUT_TDATA_W-1:0]   m_tdata   // longest_length, removals_needed
);
	import lir_pkg::*;

	lir_ctl_t             ctl;
	lir_sts_t             sts;
	logic [OUT_LEN_W-1:0] res_len;
	logic [OUT_REM_W-1:0] res_rem;

	lir_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	lir_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_value  (s_tdata),
		.in_last   (s_tlast),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_len   (res_len),
		.res_rem   (res_rem)
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, res_rem, res_len};

endmodule

>>> rtl/lir_chk.sv
// Port-level checker for the increasing-run engine, bound to the top level.
module lir_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [lir_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import lir_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a search always follows an accepted transaction
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_LEN_W-1:0] != '0) &&
			(m_tdata[OUT_LEN_W-1:0] <= OUT_LEN_W'(MAX_ITEMS)))
		else $error("longest length out of range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_LEN_W+OUT_REM_W] == '0)
		else $error("padding bits set");

endmodule

bind longest_increasing_run_engine_top lir_chk u_lir_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
